### rtl/cti_pkg.sv
// Shared types and constants of the correlation trend indicator.
// No dependencies; imported by cti_front, cti_back, the top level and the bench.
`timescale 1ns / 1ps
`default_nettype none
package cti_pkg;

  localparam int SAMPLE_W   = 24;  // price sample, 8 fraction bits
  localparam int RESULT_W   = 16;  // Q1.15 correlation
  localparam int LEN_W      = 7;   // window length register
  localparam int Q_W        = 15;  // magnitude bits found by the search
  localparam int DSQ_W      = 2 * (Q_W + 1);
  localparam int RSHIFT     = 32;  // scale of |num|^2 in the bound test
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd20;

  // Oldest sample waiting in the input queue.
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] sample;
  } head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_MUL,
    ST_DIFF,
    ST_SQ,
    ST_TEST,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

### rtl/cti_mul.sv
// Digit-serial multiplier, one 8-bit digit of b per cycle, MSB digit first.
// Uses no package; instantiated by cti_back.
`timescale 1ns / 1ps
`default_nettype none
module cti_mul #(
  parameter int AW = 90,
  parameter int BW = 45
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic                  done,
  output logic [AW+BW-1:0]      p
);
  localparam int DW  = 8;
  localparam int ND  = (BW + DW - 1) / DW;
  localparam int CW  = $clog2(ND + 1);

  logic [AW-1:0]    a_reg;
  logic [ND*DW-1:0] bq;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [AW+DW-1:0] part;

  assign part = a_reg * bq[ND*DW-1 -: DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(ND);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a_reg <= a;
      bq    <= (ND*DW)'(b);
      p     <= '0;
    end else if (busy) begin
      bq <= bq << DW;
      p  <= (p << DW) + (AW+BW)'(part);
    end
  end

endmodule
`default_nettype wire

### rtl/cti_front.sv
// Input side: a two-entry sample queue that takes stream transactions.
// Depends on cti_pkg (head_t).
`timescale 1ns / 1ps
`default_nettype none
module cti_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [cti_pkg::SAMPLE_W-1:0] s_sample,
  input  wire logic                      pop,
  output cti_pkg::head_t                 head
);
  import cti_pkg::*;

  logic [SAMPLE_W-1:0] q0, q1;
  logic [1:0]          cnt;
  logic                push;

  assign s_tready = (cnt != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign head     = '{valid: (cnt != 2'd0), sample: q0};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push && !pop) begin
      cnt <= cnt + 2'd1;
    end else if (pop && !push) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (cnt == 2'd0) q0 <= s_sample;
      else q1 <= s_sample;
    end else if (pop && !push) begin
      q0 <= q1;
    end else if (pop && push) begin
      if (cnt == 2'd1) begin
        q0 <= s_sample;
      end else begin
        q0 <= q1;
        q1 <= s_sample;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/cti_back.sv
// Back end: sample ring, window sums sweep, exact correlation by bit search.
// Depends on cti_pkg and cti_mul.
`timescale 1ns / 1ps
`default_nettype none
module cti_back #(
  parameter int WINDOW_MAX = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [cti_pkg::LEN_W-1:0]     window_length,
  input  cti_pkg::head_t                     head,
  output logic                               pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [cti_pkg::RESULT_W-1:0]       m_tdata
);
  import cti_pkg::*;

  localparam int NW   = $clog2(WINDOW_MAX + 1);
  localparam int KW   = $clog2(WINDOW_MAX);
  localparam int SXW  = SAMPLE_W + NW;
  localparam int SXXW = 2 * SAMPLE_W + NW;
  localparam int SKW  = SAMPLE_W + 2 * NW;
  localparam int SYYW = 3 * NW;
  localparam int TW   = 2 * NW;
  localparam int VXW  = SXXW + NW;
  localparam int VYW  = SYYW + NW;
  localparam int MAGW = SAMPLE_W + 3 * NW;
  localparam int VXYW = VXW + VYW;
  localparam int PW   = 2 * MAGW + RSHIFT;
  localparam int MAW  = VXYW;
  localparam int MBW  = (MAGW > DSQ_W) ? MAGW : DSQ_W;
  localparam int CLW  = ((NW > LEN_W) ? NW : LEN_W) + 1;
  localparam int BTW  = $clog2(Q_W);

  typedef enum logic [2:0] {
    OP_NSXX, OP_SXSQ, OP_TSX, OP_NSK, OP_NSYY, OP_TT, OP_MAGSQ, OP_VXY
  } mul_op_t;

  state_t  state, state_next;
  mul_op_t op;

  // ring of samples; entries of age count and above read as zero
  logic [SAMPLE_W-1:0] mem [WINDOW_MAX];
  logic [SAMPLE_W-1:0] rd_data;
  logic [KW-1:0]       wptr, newest, rd_addr, rd_k;
  logic [NW-1:0]       count, nn, kis, nn_c;
  logic                rd_v;

  logic [SXW-1:0]  sx;
  logic [SXXW-1:0] sxx;
  logic [SKW-1:0]  sk;
  logic [SYYW-1:0] syy;
  logic [TW-1:0]   tval;

  logic [VXW-1:0]  p_nsxx, p_sxsq, vx;
  logic [MAGW-1:0] p_tsx, p_nsk, mag;
  logic [VYW-1:0]  p_nsyy, p_tt, vy;
  logic [2*MAGW-1:0] msq;
  logic [VXYW-1:0] vxy;
  logic            neg;

  logic [Q_W-1:0]   q, cand;
  logic [BTW-1:0]   bitn;
  logic [DSQ_W-1:0] dsq;

  logic issued, mul_start, mul_done;
  logic [MAW-1:0] mul_a;
  logic [MBW-1:0] mul_b;
  logic [MAW+MBW-1:0] mul_p;

  logic [SAMPLE_W-1:0]   x;
  logic [2*SAMPLE_W-1:0] xsq;
  logic [SAMPLE_W+KW-1:0] kx;
  logic [2*NW-1:0]       ksq;
  logic [VXW-1:0]        vx_c;
  logic [VYW-1:0]        vy_c;
  logic [MAGW:0]         num_c;
  logic [Q_W-1:0]        q_try;
  logic [Q_W:0]          d;
  logic [RESULT_W-1:0]   res;
  logic [CLW-1:0]        wl_ext;

  assign wl_ext = CLW'(window_length);
  assign nn_c   = (wl_ext > CLW'(WINDOW_MAX)) ? NW'(WINDOW_MAX) : NW'(window_length);

  assign rd_addr = (kis > NW'(newest)) ? KW'(NW'(newest) + NW'(WINDOW_MAX) - kis)
                                       : KW'(NW'(newest) - kis);
  assign x   = (NW'(rd_k) < count) ? rd_data : '0;
  assign xsq = x * x;
  assign kx  = rd_k * x;
  assign ksq = kis * kis;

  assign vx_c  = p_nsxx - p_sxsq;
  assign vy_c  = p_nsyy - p_tt;
  assign num_c = {1'b0, p_tsx} - {1'b0, p_nsk};

  assign q_try = q | (Q_W'(1) << bitn);
  assign d     = {q_try, 1'b0} - (Q_W+1)'(1);
  assign res   = neg ? (RESULT_W'(0) - RESULT_W'(q)) : RESULT_W'(q);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (head.valid) state_next = ST_SWEEP;
      ST_SWEEP: if (kis == nn && !rd_v) state_next = ST_MUL;
      ST_MUL: begin
        if (mul_done) begin
          if (op == OP_TT) state_next = ST_DIFF;
          else if (op == OP_VXY) state_next = ST_SQ;
        end
      end
      ST_DIFF:  state_next = (vx_c == '0 || vy_c == '0) ? ST_OUT : ST_MUL;
      ST_SQ:    state_next = ST_TEST;
      ST_TEST:  if (mul_done) state_next = (bitn == '0) ? ST_OUT : ST_SQ;
      ST_OUT:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = (state == ST_IDLE) && head.valid;
    mul_start = (state == ST_MUL || state == ST_TEST) && !issued;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_TEST) begin
      mul_a = MAW'(vxy);
      mul_b = MBW'(dsq);
    end else begin
      case (op)
        OP_NSXX:  begin mul_a = MAW'(sxx);  mul_b = MBW'(nn);   end
        OP_SXSQ:  begin mul_a = MAW'(sx);   mul_b = MBW'(sx);   end
        OP_TSX:   begin mul_a = MAW'(sx);   mul_b = MBW'(tval); end
        OP_NSK:   begin mul_a = MAW'(sk);   mul_b = MBW'(nn);   end
        OP_NSYY:  begin mul_a = MAW'(syy);  mul_b = MBW'(nn);   end
        OP_TT:    begin mul_a = MAW'(tval); mul_b = MBW'(tval); end
        OP_MAGSQ: begin mul_a = MAW'(mag);  mul_b = MBW'(mag);  end
        OP_VXY:   begin mul_a = MAW'(vx);   mul_b = MBW'(vy);   end
        default:  begin mul_a = '0;         mul_b = '0;         end
      endcase
    end
  end

  cti_mul #(.AW(MAW), .BW(MBW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (pop) mem[wptr] <= head.sample;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wptr     <= '0;
      count    <= '0;
      issued   <= 1'b0;
      rd_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        wptr  <= (wptr == KW'(WINDOW_MAX - 1)) ? '0 : wptr + 1'b1;
        count <= (count == NW'(WINDOW_MAX)) ? count : count + 1'b1;
      end
      if (mul_start) issued <= 1'b1;
      else if (mul_done) issued <= 1'b0;
      rd_v <= (state == ST_SWEEP) && (kis < nn);
      if (state == ST_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) m_tdata <= res;
    case (state)
      ST_IDLE: begin
        newest <= wptr;
        nn     <= nn_c;
        tval   <= (nn_c == '0) ? '0 : TW'((TW'(nn_c) * TW'(nn_c - 1'b1)) >> 1);
        kis    <= '0;
        sx     <= '0;
        sxx    <= '0;
        sk     <= '0;
        syy    <= '0;
        op     <= OP_NSXX;
      end
      ST_SWEEP: begin
        if (kis < nn) begin
          rd_k <= KW'(kis);
          syy  <= syy + SYYW'(ksq);
          kis  <= kis + 1'b1;
        end
        if (rd_v) begin
          sx  <= sx + SXW'(x);
          sxx <= sxx + SXXW'(xsq);
          sk  <= sk + SKW'(kx);
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          case (op)
            OP_NSXX:  p_nsxx <= mul_p[VXW-1:0];
            OP_SXSQ:  p_sxsq <= mul_p[VXW-1:0];
            OP_TSX:   p_tsx  <= mul_p[MAGW-1:0];
            OP_NSK:   p_nsk  <= mul_p[MAGW-1:0];
            OP_NSYY:  p_nsyy <= mul_p[VYW-1:0];
            OP_TT:    p_tt   <= mul_p[VYW-1:0];
            OP_MAGSQ: msq    <= mul_p[2*MAGW-1:0];
            OP_VXY:   vxy    <= mul_p[VXYW-1:0];
            default:  ;
          endcase
          op <= mul_op_t'(op + 3'd1);
          if (op == OP_VXY) begin
            q    <= '0;
            bitn <= BTW'(Q_W - 1);
          end
        end
      end
      ST_DIFF: begin
        vx  <= vx_c;
        vy  <= vy_c;
        neg <= num_c[MAGW];
        mag <= num_c[MAGW] ? MAGW'(-num_c) : num_c[MAGW-1:0];
        q   <= '0;
      end
      ST_SQ: begin
        cand <= q_try;
        dsq  <= d * d;
      end
      ST_TEST: begin
        if (mul_done) begin
          if (mul_p[PW-1:0] <= {msq, RSHIFT'(0)}) q <= cand;
          bitn <= bitn - 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### rtl/correlation_trend_indicator.sv
// Correlation trend indicator: Pearson correlation of recent prices vs. time.
// Top level; depends on cti_pkg, cti_front, cti_back (and cti_mul below it).
//
// Usage:
//  - s_tvalid/s_tready/s_tdata: one price sample per transaction, unsigned,
//    8 fraction bits. A two-entry queue takes samples while the back end works.
//  - m_tvalid/m_tready/m_tdata: exactly one signed Q1.15 result per sample,
//    correlation of the newest n samples with a descending ramp, +-32767.
//  - cfg_valid/cfg_ready/cfg_data: window length n (reset 20), clamped to
//    WINDOW_MAX. Write only while no sample is in flight. cfg_ready is always 1.
// Processing: a sum sweep over the window (one ring read per cycle), eight
//   setup products and 15 bit-search products, all on the shared serial
//   multiplier, which takes ND = ceil(max(45, 32) / 8) = 6 digits of b at
//   WINDOW_MAX = 64. One sample is processed at a time.
// Reset: window reads as all zeros (fill count), sums clear, n returns to 20.
// Stall: a finished result sits in the output register; the back end waits
//   only when a second result is ready before the first is taken. Input keeps
//   flowing into the queue until it holds two samples.
`timescale 1ns / 1ps
`default_nettype none
module correlation_trend_indicator #(
  parameter int WINDOW_MAX = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [23:0] price_sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [15:0] trend_correlation
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data   // [6:0] window_length
);
  import cti_pkg::*;

  logic [LEN_W-1:0] window_length;
  head_t            head;
  logic             pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_length <= cfg_data;
    end
  end

  cti_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_sample (s_tdata),
    .pop      (pop),
    .head     (head)
  );

  cti_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
    .clk           (clk),
    .rst           (rst),
    .window_length (window_length),
    .head          (head),
    .pop           (pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata)
  );

endmodule
`default_nettype wire

### rtl/cti_checker.sv
// Port-level checks of the correlation trend indicator, bound to the top level.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none
module cti_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_no_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata != 16'h8000)
    else $error("result outside saturation range");

  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("reset left a result pending or queue full");

  a_cfg_rdy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind correlation_trend_indicator cti_checker u_cti_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
`default_nettype wire

### tb/testbench.sv
// Self-checking bench for correlation_trend_indicator: drives price samples,
// predicts each Q1.15 correlation in integer math, and checks every result.
// Depends on rtl/cti_pkg.sv and the block's RTL.
`timescale 1ns / 1ps
module testbench;
  import cti_pkg::*;

  localparam int WMAX = 64;
  localparam int LIMIT_CYCLES = 2000000;

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [23:0] s_tdata;       // [23:0] price_sample
  logic m_tvalid, m_tready;
  logic [15:0] m_tdata;       // [15:0] trend_correlation
  logic cfg_valid, cfg_ready;
  logic [6:0] cfg_data;       // [6:0] window_length

  correlation_trend_indicator #(.WINDOW_MAX(WMAX)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Predictor state: sample history (newest at 0) and current length.
  logic [23:0] price_hist [WMAX];
  logic [6:0]  win_len;
  logic [15:0] corr_q[$];     // expected correlations, oldest first
  int errors, accepted_in, accepted_out, cycles;
  int send_idle_pct, recv_idle_pct;

  // Push one sample and return the expected correlation.
  function automatic logic [15:0] predict_corr(logic [23:0] px);
    longint unsigned n, sx, sxx, sk, vx, vy, num, mag, c, d, q;
    logic [127:0] lhs, bound;
    bit neg;
    n = (win_len > WMAX) ? WMAX : win_len;
    for (int i = WMAX - 1; i > 0; i--) price_hist[i] = price_hist[i-1];
    price_hist[0] = px;
    sx = 0; sxx = 0; sk = 0;
    for (int k = 0; k < n; k++) begin
      sx += price_hist[k];
      sxx += longint'(price_hist[k]) * price_hist[k];
      sk += k * price_hist[k];
    end
    vx = n * sxx - sx * sx;
    vy = (n * n * (n * n - 1)) / 12;
    if (vx == 0 || vy == 0) return 16'd0;
    num = ((n * (n - 1)) / 2) * sx - n * sk;
    neg = num[63];
    mag = neg ? -num : num;
    bound = ({64'd0, mag} * {64'd0, mag}) << 32;
    q = 0;
    // Binary search for the rounded magnitude: largest q with (2q-1)^2 vx vy <= 4*mag^2*2^30
    for (int b = 14; b >= 0; b--) begin
      c = q | (64'd1 << b);
      d = 2 * c - 1;
      lhs = {64'd0, d * d * vy} * {64'd0, vx};
      if (lhs <= bound) q = c;
    end
    return neg ? 16'(17'h10000 - q) : 16'(q);
  endfunction

  // Write window_length while idle; predictor follows.
  task automatic write_len(logic [6:0] v);
    @(posedge clk);
    cfg_valid <= 1; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    win_len = v;
  endtask

  // Send one sample; expected value is either typed in (use_fixed) or predicted.
  // tvalid drops only in idle cycles, so back-to-back samples keep it high.
  task automatic send_price(logic [23:0] px, bit use_fixed, logic [15:0] fixed);
    logic [15:0] e;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1; s_tdata <= px;
    do @(posedge clk); while (!s_tready);
    e = predict_corr(px);
    if (use_fixed && e != fixed)
      $display("%0t: directed row disagrees with predictor: %0d vs %0d",
               $time, $signed(fixed), $signed(e));
    corr_q.push_back(use_fixed ? fixed : e);
    accepted_in++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (corr_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);  // idle time after the last result
  endtask

  // Receiver: random stalls, compare each result with oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        accepted_out++;
        if (corr_q.size() == 0) begin
          $display("%0t: unexpected result %0d", $time, $signed(m_tdata));
          errors++;
        end else begin
          if (m_tdata !== corr_q[0]) begin
            $display("%0t: trend_correlation expected %0d actual %0d", $time,
                     $signed(corr_q[0]), $signed(m_tdata));
            errors++;
          end
          void'(corr_q.pop_front());
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  typedef struct {
    logic [23:0] price;
    bit          fixed_ok;
    logic [15:0] want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    logic [6:0] lens[$];
    errors = 0; accepted_in = 0; accepted_out = 0; cycles = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    s_tvalid = 0; s_tdata = 0; cfg_valid = 0; cfg_data = 0;
    for (int i = 0; i < WMAX; i++) price_hist[i] = 0;
    win_len = LEN_RESET;
    rst = 1;
    repeat (11) @(posedge clk);
    rst <= 0;

    // Directed: warm-up, extremes, flat data, rising/falling ramps.
    dir_rows = '{
      '{24'd0, 1'b1, 16'd0},          // all zeros after reset: flat
      '{24'hFFFFFF, 1'b0, 16'd0},     // newest max among zeros
      '{24'hFFFFFF, 1'b0, 16'd0},
      '{24'd0, 1'b0, 16'd0},
      '{24'h000001, 1'b0, 16'd0},
      '{24'h800000, 1'b0, 16'd0},
      '{24'h7FFFFF, 1'b0, 16'd0},
      '{24'h555555, 1'b0, 16'd0},
      '{24'hAAAAAA, 1'b0, 16'd0}
    };
    foreach (dir_rows[i]) send_price(dir_rows[i].price, dir_rows[i].fixed_ok, dir_rows[i].want);
    drain();
    write_len(7'd1);               // length one: always zero
    send_price(24'h123456, 1'b1, 16'd0);
    send_price(24'hFFFFFF, 1'b1, 16'd0);
    drain();
    write_len(7'd2);
    for (int i = 0; i < 4; i++) send_price(24'(i * 1000), 1'b0, 16'd0);  // perfect rise
    for (int i = 0; i < 4; i++) send_price(24'(9000 - i * 1000), 1'b0, 16'd0);
    drain();
    write_len(7'd127);             // clamps to WINDOW_MAX
    for (int i = 0; i < 4; i++) send_price(24'hFFFFFF - 24'(i), 1'b0, 16'd0);
    drain();
    write_len(7'd0);
    send_price(24'd42, 1'b1, 16'd0);
    drain();

    // Random phases with several lengths and idle patterns.
    lens = '{7'd64, 7'd3, 7'd20, 7'd100, 7'd7, 7'd1, 7'd33, 7'd2, 7'd64};
    for (int ph = 0; ph < 9; ph++) begin
      send_idle_pct = (ph < 3) ? 16 : (ph < 6) ? 81 : 0;
      recv_idle_pct = (ph < 3) ? 81 : (ph < 6) ? 16 : 0;
      write_len(lens[ph]);
      for (int i = 0; i < 70; i++) begin
        logic [23:0] px;
        case ($urandom_range(3))
          0: px = 24'($urandom);                              // noise
          1: px = 24'(1000 + i * 37 + $urandom_range(20));     // trending
          2: px = $urandom_range(1) ? 24'hFFFFFF : 24'd0;     // extremes
          default: px = 24'h400000;                           // flat stretch
        endcase
        send_price(px, 1'b0, 16'd0);
      end
      drain();
    end

    $display("covered %0d samples, %0d results, lengths 0..127 incl. clamp and flat cases",
             accepted_in, accepted_out);
    if (errors == 0 && corr_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
